// File: hdl/lur_pkg.sv
// Shared types, field widths, codes and defaults for the lens undistortion remap block.
package lur_pkg;

  localparam int unsigned MAX_IMG_WIDTH_DEF  = 640;
  localparam int unsigned MAX_IMG_HEIGHT_DEF = 240;
  localparam int unsigned DEST_WIDTH_DEF     = 320;
  localparam int unsigned DEST_HEIGHT_DEF    = 120;
  localparam int unsigned MAP_SIZE_DEF       = 64;

  localparam int unsigned FUNC_BITS    = 2;
  localparam int unsigned MAP_IDX_BITS = 6;
  localparam int unsigned MAP_VAL_BITS = 20;
  localparam int unsigned PIX_X_BITS   = 10;
  localparam int unsigned PIX_Y_BITS   = 8;
  localparam int unsigned PIX_VAL_BITS = 8;
  localparam int unsigned DEST_X_BITS  = 9;
  localparam int unsigned DEST_Y_BITS  = 7;
  localparam int unsigned CFG_W_BITS   = 10;
  localparam int unsigned CFG_H_BITS   = 8;
  localparam int unsigned CFG_IDX_BITS = 1;
  localparam int unsigned CFG_DATA_BITS = 10;

  localparam logic [FUNC_BITS-1:0] FUNC_MAP_LOAD = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_PIX_LOAD = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_COMPUTE  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_IMG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMG_HEIGHT = 1'd1;

  localparam logic [CFG_W_BITS-1:0]   IMG_WIDTH_RST  = 10'd640;
  localparam logic [CFG_H_BITS-1:0]   IMG_HEIGHT_RST = 8'd240;
  localparam logic [PIX_VAL_BITS-1:0] REJECT_PIXEL   = 8'd255;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_MAP,
    KIND_PIX,
    KIND_CMP
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic [MAP_IDX_BITS-1:0]  map_col;
    logic [MAP_IDX_BITS-1:0]  map_row;
    logic [MAP_VAL_BITS-1:0]  map_dx;
    logic [MAP_VAL_BITS-1:0]  map_dy;
    logic [PIX_X_BITS-1:0]    pix_x;
    logic [PIX_Y_BITS-1:0]    pix_y;
    logic [PIX_VAL_BITS-1:0]  pix_val;
    logic [DEST_X_BITS-1:0]   dest_x;
    logic [DEST_Y_BITS-1:0]   dest_y;
  } item_t;

endpackage

// File: hdl/lens_undistort_remap.sv
// Top level of the lens undistortion remap block: config registers and pipeline wiring.
//
// Requests enter on in_valid_i/in_ready_o. func_i selects a map point load, a raw
// pixel load or a compute request; loads and unused codes give no result. A compute
// request gives one result on out_valid_o/out_ready_i: the raw pixel found through
// the bilinear calibration map, or 255 with in_range_o low when the point falls
// outside the unit square.
// Image size is written on cfg_valid_i/cfg_ready_o (index 0 width, 1 height); the
// port is always ready. The user must write it only while the block is idle; the
// block does not enforce this. Throughput is one request per cycle while the queue is
// not full; a compute request passes the queue and ten stages to the output register.
// A four-entry queue decouples the front from the pipeline; when the receiver stalls,
// the pipeline holds and the queue keeps taking requests until it fills.
// Reset empties the queue and pipeline and sets width 640, height 240; the map and
// image stores hold no defined data until written.
module lens_undistort_remap #(
  parameter int unsigned MAX_IMG_WIDTH  = lur_pkg::MAX_IMG_WIDTH_DEF,
  parameter int unsigned MAX_IMG_HEIGHT = lur_pkg::MAX_IMG_HEIGHT_DEF,
  parameter int unsigned DEST_WIDTH     = lur_pkg::DEST_WIDTH_DEF,
  parameter int unsigned DEST_HEIGHT    = lur_pkg::DEST_HEIGHT_DEF,
  parameter int unsigned MAP_SIZE       = lur_pkg::MAP_SIZE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lur_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [lur_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [lur_pkg::FUNC_BITS-1:0]      func_i,
  input  logic [lur_pkg::MAP_IDX_BITS-1:0]   map_col_i,
  input  logic [lur_pkg::MAP_IDX_BITS-1:0]   map_row_i,
  input  logic [lur_pkg::MAP_VAL_BITS-1:0]   map_dx_i,
  input  logic [lur_pkg::MAP_VAL_BITS-1:0]   map_dy_i,
  input  logic [lur_pkg::PIX_X_BITS-1:0]     pixel_x_i,
  input  logic [lur_pkg::PIX_Y_BITS-1:0]     pixel_y_i,
  input  logic [lur_pkg::PIX_VAL_BITS-1:0]   pixel_value_i,
  input  logic [lur_pkg::DEST_X_BITS-1:0]    dest_x_i,
  input  logic [lur_pkg::DEST_Y_BITS-1:0]    dest_y_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [lur_pkg::PIX_VAL_BITS-1:0]   pixel_out_o,
  output logic                               in_range_o
);
  import lur_pkg::*;

  logic [CFG_W_BITS-1:0] img_w_q, img_w_sat;
  logic [CFG_H_BITS-1:0] img_h_q, img_h_sat;
  logic  full, push, pop, head_valid;
  item_t front_item, head_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= IMG_WIDTH_RST;
      img_h_q <= IMG_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_IMG_WIDTH:  img_w_q <= cfg_data_i[CFG_W_BITS-1:0];
        REG_IMG_HEIGHT: img_h_q <= cfg_data_i[CFG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // saturate sizes into [1, max]
  always_comb begin
    img_w_sat = img_w_q;
    if (img_w_q == '0) img_w_sat = CFG_W_BITS'(1);
    else if (32'(img_w_q) > MAX_IMG_WIDTH) img_w_sat = CFG_W_BITS'(MAX_IMG_WIDTH);
    img_h_sat = img_h_q;
    if (img_h_q == '0) img_h_sat = CFG_H_BITS'(1);
    else if (32'(img_h_q) > MAX_IMG_HEIGHT) img_h_sat = CFG_H_BITS'(MAX_IMG_HEIGHT);
  end

  lur_front #(
    .MAX_IMG_WIDTH (MAX_IMG_WIDTH),
    .MAX_IMG_HEIGHT(MAX_IMG_HEIGHT),
    .DEST_WIDTH    (DEST_WIDTH),
    .DEST_HEIGHT   (DEST_HEIGHT),
    .MAP_SIZE      (MAP_SIZE)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .map_col_i    (map_col_i),
    .map_row_i    (map_row_i),
    .map_dx_i     (map_dx_i),
    .map_dy_i     (map_dy_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .pixel_value_i(pixel_value_i),
    .dest_x_i     (dest_x_i),
    .dest_y_i     (dest_y_i),
    .full_i       (full),
    .push_o       (push),
    .item_o       (front_item)
  );

  lur_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .item_o (head_item)
  );

  lur_back #(
    .MAX_IMG_WIDTH (MAX_IMG_WIDTH),
    .MAX_IMG_HEIGHT(MAX_IMG_HEIGHT),
    .DEST_WIDTH    (DEST_WIDTH),
    .DEST_HEIGHT   (DEST_HEIGHT),
    .MAP_SIZE      (MAP_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head_item),
    .pop_o       (pop),
    .img_w_i     (img_w_sat),
    .img_h_i     (img_h_sat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o),
    .in_range_o  (in_range_o)
  );

endmodule

// File: hdl/lur_front.sv
// Front end: accepts requests, drops ignored ones, saturates destination coordinates.
module lur_front #(
  parameter int unsigned MAX_IMG_WIDTH  = lur_pkg::MAX_IMG_WIDTH_DEF,
  parameter int unsigned MAX_IMG_HEIGHT = lur_pkg::MAX_IMG_HEIGHT_DEF,
  parameter int unsigned DEST_WIDTH     = lur_pkg::DEST_WIDTH_DEF,
  parameter int unsigned DEST_HEIGHT    = lur_pkg::DEST_HEIGHT_DEF,
  parameter int unsigned MAP_SIZE       = lur_pkg::MAP_SIZE_DEF
) (
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lur_pkg::FUNC_BITS-1:0]     func_i,
  input  logic [lur_pkg::MAP_IDX_BITS-1:0]  map_col_i,
  input  logic [lur_pkg::MAP_IDX_BITS-1:0]  map_row_i,
  input  logic [lur_pkg::MAP_VAL_BITS-1:0]  map_dx_i,
  input  logic [lur_pkg::MAP_VAL_BITS-1:0]  map_dy_i,
  input  logic [lur_pkg::PIX_X_BITS-1:0]    pixel_x_i,
  input  logic [lur_pkg::PIX_Y_BITS-1:0]    pixel_y_i,
  input  logic [lur_pkg::PIX_VAL_BITS-1:0]  pixel_value_i,
  input  logic [lur_pkg::DEST_X_BITS-1:0]   dest_x_i,
  input  logic [lur_pkg::DEST_Y_BITS-1:0]   dest_y_i,
  input  logic                              full_i,
  output logic                              push_o,
  output lur_pkg::item_t                    item_o
);
  import lur_pkg::*;

  logic keep;

  always_comb begin
    item_o         = '0;
    item_o.map_col = map_col_i;
    item_o.map_row = map_row_i;
    item_o.map_dx  = map_dx_i;
    item_o.map_dy  = map_dy_i;
    item_o.pix_x   = pixel_x_i;
    item_o.pix_y   = pixel_y_i;
    item_o.pix_val = pixel_value_i;
    item_o.dest_x  = dest_x_i;
    item_o.dest_y  = dest_y_i;
    if (32'(dest_x_i) > DEST_WIDTH - 1) item_o.dest_x = DEST_X_BITS'(DEST_WIDTH - 1);
    if (32'(dest_y_i) > DEST_HEIGHT - 1) item_o.dest_y = DEST_Y_BITS'(DEST_HEIGHT - 1);
    keep        = 1'b0;
    item_o.kind = KIND_CMP;
    unique case (func_i)
      FUNC_MAP_LOAD: begin
        item_o.kind = KIND_MAP;
        keep = (32'(map_col_i) < MAP_SIZE) && (32'(map_row_i) < MAP_SIZE);
      end
      FUNC_PIX_LOAD: begin
        item_o.kind = KIND_PIX;
        keep = (32'(pixel_x_i) < MAX_IMG_WIDTH) && (32'(pixel_y_i) < MAX_IMG_HEIGHT);
      end
      FUNC_COMPUTE: begin
        item_o.kind = KIND_CMP;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i && keep;

endmodule

// File: hdl/lur_fifo.sv
// Short request queue between the front end and the compute pipeline.
module lur_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lur_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output lur_pkg::item_t item_o
);
  import lur_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  item_t         mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (PW+1)'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + PW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

// File: hdl/lur_back.sv
// Compute pipeline: map lookup in four banks, bilinear blend, denormalize, pixel fetch.
module lur_back #(
  parameter int unsigned MAX_IMG_WIDTH  = lur_pkg::MAX_IMG_WIDTH_DEF,
  parameter int unsigned MAX_IMG_HEIGHT = lur_pkg::MAX_IMG_HEIGHT_DEF,
  parameter int unsigned DEST_WIDTH     = lur_pkg::DEST_WIDTH_DEF,
  parameter int unsigned DEST_HEIGHT    = lur_pkg::DEST_HEIGHT_DEF,
  parameter int unsigned MAP_SIZE       = lur_pkg::MAP_SIZE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              head_valid_i,
  input  lur_pkg::item_t                    head_i,
  output logic                              pop_o,
  input  logic [lur_pkg::CFG_W_BITS-1:0]    img_w_i,
  input  logic [lur_pkg::CFG_H_BITS-1:0]    img_h_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lur_pkg::PIX_VAL_BITS-1:0]  pixel_out_o,
  output logic                              in_range_o
);
  import lur_pkg::*;

  localparam int unsigned MW     = $clog2(MAP_SIZE);
  localparam int unsigned HALF   = (MAP_SIZE + 1) / 2;
  localparam int unsigned BDEPTH = HALF * HALF;
  localparam int unsigned BAW    = $clog2(BDEPTH);
  localparam int unsigned XW     = $clog2(DEST_WIDTH);
  localparam int unsigned YW     = $clog2(DEST_HEIGHT);
  localparam int unsigned NXW    = $clog2((MAP_SIZE - 1) * (DEST_WIDTH - 1) + 1);
  localparam int unsigned NYW    = $clog2((MAP_SIZE - 2) * DEST_HEIGHT + 1);
  localparam longint unsigned RX_RECIP = (64'd1 << NXW) / DEST_WIDTH;
  localparam longint unsigned RY_RECIP = (64'd1 << NYW) / DEST_HEIGHT;
  localparam int unsigned RXRW   = $clog2(RX_RECIP + 1);
  localparam int unsigned RYRW   = $clog2(RY_RECIP + 1);
  localparam int unsigned WPW    = $clog2(DEST_WIDTH * DEST_HEIGHT + 1);
  localparam int unsigned PRW    = MAP_VAL_BITS + WPW + 1;
  localparam int unsigned SW     = PRW + 2;
  localparam longint unsigned DWDH = 64'(DEST_WIDTH) * 64'(DEST_HEIGHT);
  localparam longint unsigned ONE  = 64'd65536 * DWDH;
  localparam int unsigned SUW    = $clog2(ONE + 1);
  localparam int unsigned TXW    = SUW + CFG_W_BITS - 16;
  localparam int unsigned TYW    = SUW + CFG_H_BITS - 16;
  localparam longint unsigned DX_RECIP = (64'd1 << TXW) / DWDH;
  localparam longint unsigned DY_RECIP = (64'd1 << TYW) / DWDH;
  localparam int unsigned DXRW   = $clog2(DX_RECIP + 1);
  localparam int unsigned DYRW   = $clog2(DY_RECIP + 1);
  localparam int unsigned PDEPTH = MAX_IMG_WIDTH * MAX_IMG_HEIGHT;
  localparam int unsigned PAW    = $clog2(PDEPTH);
  localparam int unsigned DW2    = 2 * MAP_VAL_BITS;

  logic        adv;
  logic [10:1] vld_q;
  item_t       item_q [1:10];

  // stage registers
  logic [NXW-1:0] nx1_q, nx2_q;
  logic [NYW-1:0] ny1_q, ny2_q;
  logic [MW-1:0]  qx2_q, qy2_q, x1_3_q, y1_3_q;
  logic [XW-1:0]  rx3_q;
  logic [YW-1:0]  ry3_q;
  logic [WPW-1:0] wgt4_q [4];
  logic           x1p4_q, y1p4_q;
  logic signed [PRW-1:0] pxs5_q [4];
  logic signed [PRW-1:0] pys5_q [4];
  logic signed [SW-1:0]  sx6_q, sy6_q;
  logic           ok7_q, ok8_q, ok9_q, ok10_q;
  logic [TXW-1:0] tx7_q, tx8_q;
  logic [TYW-1:0] ty7_q, ty8_q;
  logic [CFG_W_BITS-1:0] qdx8_q, dxp9_q;
  logic [CFG_H_BITS-1:0] qdy8_q, dyp9_q;
  logic [PAW-1:0] addr10_q;
  logic           out_valid_q, out_ok_q;
  logic [PIX_VAL_BITS-1:0] pix_rd_q;

  // stage logic
  logic [NXW+RXRW-1:0] qx_prod;
  logic [NYW+RYRW-1:0] qy_prod;
  logic [NXW-1:0]      rx_full;
  logic [NYW-1:0]      ry_full;
  logic [MW-1:0]       x2_3, y2_3;
  logic [BAW-1:0]      bank_rd_addr [4];
  logic [DW2-1:0]      bank_rd [4];
  logic                map_we;
  logic [1:0]          map_wr_bank;
  logic [BAW-1:0]      map_wr_addr;
  logic signed [PRW-1:0] prod_x [4];
  logic signed [PRW-1:0] prod_y [4];
  logic [SUW+CFG_W_BITS-1:0] mul_x;
  logic [SUW+CFG_H_BITS-1:0] mul_y;
  logic [TXW+DXRW-1:0] dx_prod;
  logic [TYW+DYRW-1:0] dy_prod;
  logic [TXW-1:0]      rem_x;
  logic [TYW-1:0]      rem_y;
  logic [CFG_W_BITS-1:0] dxq;
  logic [CFG_H_BITS-1:0] dyq;
  logic [PAW-1:0]      addr_c;
  logic                pix_we;

  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && head_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[9:1], head_valid_i};
      out_valid_q <= vld_q[10] && (item_q[10].kind == KIND_CMP);
    end
  end

  // map index and remainder by reciprocal multiply with one correction step
  assign qx_prod = (NXW+RXRW)'(nx1_q) * (NXW+RXRW)'(RX_RECIP);
  assign qy_prod = (NYW+RYRW)'(ny1_q) * (NYW+RYRW)'(RY_RECIP);
  assign rx_full = nx2_q - NXW'(32'(qx2_q) * DEST_WIDTH);
  assign ry_full = ny2_q - NYW'(32'(qy2_q) * DEST_HEIGHT);

  // x1, y1 never exceed MAP_SIZE-2, so the right and lower neighbors need no clamp
  assign x2_3 = x1_3_q + MW'(1);
  assign y2_3 = y1_3_q + MW'(1);

  always_comb begin
    logic [MW-1:0] colv, rowv;
    for (int k = 0; k < 4; k++) begin
      colv = (x1_3_q[0] == k[0]) ? x1_3_q : x2_3;
      rowv = (y1_3_q[0] == k[1]) ? y1_3_q : y2_3;
      bank_rd_addr[k] = BAW'(32'(rowv >> 1) * HALF + 32'(colv >> 1));
    end
  end

  assign map_we      = adv && vld_q[3] && (item_q[3].kind == KIND_MAP);
  assign map_wr_bank = {item_q[3].map_row[0], item_q[3].map_col[0]};
  assign map_wr_addr = BAW'(32'(item_q[3].map_row >> 1) * HALF + 32'(item_q[3].map_col >> 1));

  // banked by row and column parity: the four neighbors always hit four banks
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [DW2-1:0] mem [BDEPTH];
    logic [DW2-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (map_we && (map_wr_bank == 2'(k))) begin
          mem[map_wr_addr] <= {item_q[3].map_dx, item_q[3].map_dy};
        end
        rd_q <= mem[bank_rd_addr[k]];
      end
    end
    assign bank_rd[k] = rd_q;
  end

  always_comb begin
    logic [1:0] bi;
    for (int t = 0; t < 4; t++) begin
      bi = {y1p4_q ^ t[1], x1p4_q ^ t[0]};
      prod_x[t] = PRW'($signed(bank_rd[bi][DW2-1:MAP_VAL_BITS])) * $signed(PRW'(wgt4_q[t]));
      prod_y[t] = PRW'($signed(bank_rd[bi][MAP_VAL_BITS-1:0])) * $signed(PRW'(wgt4_q[t]));
    end
  end

  assign mul_x = (SUW+CFG_W_BITS)'(sx6_q[SUW-1:0]) * (SUW+CFG_W_BITS)'(img_w_i);
  assign mul_y = (SUW+CFG_H_BITS)'(sy6_q[SUW-1:0]) * (SUW+CFG_H_BITS)'(img_h_i);
  assign dx_prod = (TXW+DXRW)'(tx7_q) * (TXW+DXRW)'(DX_RECIP);
  assign dy_prod = (TYW+DYRW)'(ty7_q) * (TYW+DYRW)'(DY_RECIP);
  assign rem_x = tx8_q - TXW'(64'(qdx8_q) * DWDH);
  assign rem_y = ty8_q - TYW'(64'(qdy8_q) * DWDH);

  always_comb begin
    dxq = (64'(rem_x) >= DWDH) ? qdx8_q + CFG_W_BITS'(1) : qdx8_q;
    dyq = (64'(rem_y) >= DWDH) ? qdy8_q + CFG_H_BITS'(1) : qdy8_q;
    if (dxq > img_w_i - CFG_W_BITS'(1)) dxq = img_w_i - CFG_W_BITS'(1);
    if (dyq > img_h_i - CFG_H_BITS'(1)) dyq = img_h_i - CFG_H_BITS'(1);
  end

  always_comb begin
    if (item_q[9].kind == KIND_PIX) begin
      addr_c = PAW'(32'(item_q[9].pix_y) * MAX_IMG_WIDTH + 32'(item_q[9].pix_x));
    end else begin
      addr_c = PAW'(32'(dyp9_q) * MAX_IMG_WIDTH + 32'(dxp9_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      item_q[1] <= head_i;
      for (int k = 2; k <= 10; k++) item_q[k] <= item_q[k-1];

      nx1_q <= NXW'((MAP_SIZE - 1) * 32'(head_i.dest_x));
      ny1_q <= NYW'((MAP_SIZE - 2) * (DEST_HEIGHT - 32'(head_i.dest_y)));

      nx2_q <= nx1_q;
      ny2_q <= ny1_q;
      qx2_q <= MW'(qx_prod >> NXW);
      qy2_q <= MW'(qy_prod >> NYW);

      if (32'(rx_full) >= DEST_WIDTH) begin
        x1_3_q <= qx2_q + MW'(1);
        rx3_q  <= XW'(rx_full - NXW'(DEST_WIDTH));
      end else begin
        x1_3_q <= qx2_q;
        rx3_q  <= XW'(rx_full);
      end
      if (32'(ry_full) >= DEST_HEIGHT) begin
        y1_3_q <= qy2_q + MW'(1);
        ry3_q  <= YW'(ry_full - NYW'(DEST_HEIGHT));
      end else begin
        y1_3_q <= qy2_q;
        ry3_q  <= YW'(ry_full);
      end

      wgt4_q[0] <= WPW'((DEST_WIDTH - 32'(rx3_q)) * (DEST_HEIGHT - 32'(ry3_q)));
      wgt4_q[1] <= WPW'(32'(rx3_q) * (DEST_HEIGHT - 32'(ry3_q)));
      wgt4_q[2] <= WPW'((DEST_WIDTH - 32'(rx3_q)) * 32'(ry3_q));
      wgt4_q[3] <= WPW'(32'(rx3_q) * 32'(ry3_q));
      x1p4_q    <= x1_3_q[0];
      y1p4_q    <= y1_3_q[0];

      for (int t = 0; t < 4; t++) begin
        pxs5_q[t] <= prod_x[t];
        pys5_q[t] <= prod_y[t];
      end

      sx6_q <= SW'(pxs5_q[0]) + SW'(pxs5_q[1]) + SW'(pxs5_q[2]) + SW'(pxs5_q[3]);
      sy6_q <= SW'(pys5_q[0]) + SW'(pys5_q[1]) + SW'(pys5_q[2]) + SW'(pys5_q[3]);

      ok7_q <= !sx6_q[SW-1] && (sx6_q <= $signed(SW'(ONE))) &&
               !sy6_q[SW-1] && (sy6_q <= $signed(SW'(ONE)));
      tx7_q <= mul_x[SUW+CFG_W_BITS-1:16];
      ty7_q <= mul_y[SUW+CFG_H_BITS-1:16];

      ok8_q  <= ok7_q;
      tx8_q  <= tx7_q;
      ty8_q  <= ty7_q;
      qdx8_q <= CFG_W_BITS'(dx_prod >> TXW);
      qdy8_q <= CFG_H_BITS'(dy_prod >> TYW);

      ok9_q  <= ok8_q;
      dxp9_q <= dxq;
      dyp9_q <= dyq;

      ok10_q   <= ok9_q;
      addr10_q <= addr_c;

      out_ok_q <= ok10_q;
    end
  end

  assign pix_we = adv && vld_q[10] && (item_q[10].kind == KIND_PIX);

  logic [PIX_VAL_BITS-1:0] pix_mem [PDEPTH];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (pix_we) pix_mem[addr10_q] <= item_q[10].pix_val;
      pix_rd_q <= pix_mem[addr10_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_ok_q ? pix_rd_q : REJECT_PIXEL;
  assign in_range_o  = out_ok_q;

endmodule

// File: test/tb_lens_undistort_remap.sv
// Self-checking testbench for lens_undistort_remap: directed, config sweep and random traffic.
module tb_lens_undistort_remap;
  import lur_pkg::*;

  localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned MAPN = MAP_SIZE_DEF;
  localparam int unsigned IMG_W = MAX_IMG_WIDTH_DEF;
  localparam int unsigned IMG_H = MAX_IMG_HEIGHT_DEF;
  localparam longint DW = DEST_WIDTH_DEF;
  localparam longint DH = DEST_HEIGHT_DEF;
  localparam longint UNIT = 64'd65536 * DW * DH;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct {
    logic [FUNC_BITS-1:0]    func;
    logic [MAP_IDX_BITS-1:0] col, row;
    logic [MAP_VAL_BITS-1:0] mdx, mdy;
    logic [PIX_X_BITS-1:0]   px;
    logic [PIX_Y_BITS-1:0]   py;
    logic [PIX_VAL_BITS-1:0] pv;
    logic [DEST_X_BITS-1:0]  dx;
    logic [DEST_Y_BITS-1:0]  dy;
  } req_t;

  typedef struct {
    logic [PIX_VAL_BITS-1:0] pixel;
    logic                    in_range;
  } remap_out_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0, cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0, in_ready_o;
  logic [FUNC_BITS-1:0] func_i = '0;
  logic [MAP_IDX_BITS-1:0] map_col_i = '0, map_row_i = '0;
  logic [MAP_VAL_BITS-1:0] map_dx_i = '0, map_dy_i = '0;
  logic [PIX_X_BITS-1:0] pixel_x_i = '0;
  logic [PIX_Y_BITS-1:0] pixel_y_i = '0;
  logic [PIX_VAL_BITS-1:0] pixel_value_i = '0;
  logic [DEST_X_BITS-1:0] dest_x_i = '0;
  logic [DEST_Y_BITS-1:0] dest_y_i = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  logic [PIX_VAL_BITS-1:0] pixel_out_o;
  logic in_range_o;

  lens_undistort_remap dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirror of block state
  logic signed [MAP_VAL_BITS-1:0] grid_x [MAPN*MAPN];
  logic signed [MAP_VAL_BITS-1:0] grid_y [MAPN*MAPN];
  bit grid_set [MAPN*MAPN];
  logic [PIX_VAL_BITS-1:0] raw_img [IMG_W*IMG_H];
  bit raw_set [IMG_W*IMG_H];
  logic [CFG_W_BITS-1:0] width_reg = IMG_WIDTH_RST;
  logic [CFG_H_BITS-1:0] height_reg = IMG_HEIGHT_RST;

  remap_out_t pending_pixels[$];
  bit calm = 1'b0;
  bit failed = 1'b0;
  int n_results = 0, n_rejects = 0, n_requests = 0;

  always @(negedge clk_i)
    out_ready_i = calm ? 1'b1 : ($urandom_range(99) >= 35);

  always @(posedge clk_i) begin
    remap_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result pixel=%0d in_range=%0b", pixel_out_o, in_range_o);
        failed = 1'b1;
      end else begin
        want = pending_pixels.pop_front();
        n_results++;
        if (!want.in_range) n_rejects++;
        if (pixel_out_o !== want.pixel) begin
          $error("pixel_out expected %0d actual %0d", want.pixel, pixel_out_o);
          failed = 1'b1;
        end
        if (in_range_o !== want.in_range) begin
          $error("in_range expected %0b actual %0b", want.in_range, in_range_o);
          failed = 1'b1;
        end
      end
    end
  end

  // map position of a destination pixel: four corner indexes plus remainders
  function automatic void map_corners(input logic [DEST_X_BITS-1:0] dx,
                                      input logic [DEST_Y_BITS-1:0] dy,
                                      output int unsigned cr[4],
                                      output longint rx, output longint ry);
    int unsigned i, j, nx, ny, x1, y1, x2, y2;
    i = (dx > DW - 1) ? DW - 1 : dx;
    j = (dy > DH - 1) ? DH - 1 : dy;
    nx = (MAPN - 1) * i;
    ny = (MAPN - 2) * (DH - j);
    x1 = nx / DW; rx = nx % DW;
    y1 = ny / DH; ry = ny % DH;
    x2 = (x1 + 1 > MAPN - 1) ? MAPN - 1 : x1 + 1;
    y2 = (y1 + 1 > MAPN - 1) ? MAPN - 1 : y1 + 1;
    if (x1 > MAPN - 1) x1 = MAPN - 1;
    if (y1 > MAPN - 1) y1 = MAPN - 1;
    cr[0] = y1 * MAPN + x1; cr[1] = y1 * MAPN + x2;
    cr[2] = y2 * MAPN + x1; cr[3] = y2 * MAPN + x2;
  endfunction

  function automatic longint blend_axis(input bit use_y, input int unsigned cr[4],
                                        input longint rx, input longint ry);
    longint v[4];
    for (int k = 0; k < 4; k++) v[k] = use_y ? longint'(grid_y[cr[k]]) : longint'(grid_x[cr[k]]);
    return v[0] * (DW - rx) * (DH - ry) + v[1] * rx * (DH - ry) +
           v[2] * (DW - rx) * ry + v[3] * rx * ry;
  endfunction

  // bilinear lookup; hit says the point lay in the unit square
  function automatic void undistort(input logic [DEST_X_BITS-1:0] dx,
                                    input logic [DEST_Y_BITS-1:0] dy,
                                    output bit hit, output int unsigned addr);
    int unsigned cr[4];
    longint rx, ry, sx, sy, w, h, col, row;
    map_corners(dx, dy, cr, rx, ry);
    sx = blend_axis(1'b0, cr, rx, ry);
    sy = blend_axis(1'b1, cr, rx, ry);
    w = (width_reg == 0) ? 1 : (width_reg > IMG_W) ? IMG_W : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > IMG_H) ? IMG_H : height_reg;
    hit = sx >= 0 && sx <= UNIT && sy >= 0 && sy <= UNIT;
    addr = 0;
    if (hit) begin
      col = sx * w / UNIT;
      row = sy * h / UNIT;
      if (col > w - 1) col = w - 1;
      if (row > h - 1) row = h - 1;
      addr = row * IMG_W + col;
    end
  endfunction

  function automatic logic [MAP_VAL_BITS-1:0] rand_map_val();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return MAP_VAL_BITS'($urandom_range(69536 + 4000) - 4000);
    if (pick < 85) return MAP_VAL_BITS'($urandom_range(65536));
    return MAP_VAL_BITS'($urandom);
  endfunction

  function automatic void commit_request(input req_t r);
    bit hit;
    int unsigned addr;
    remap_out_t o;
    case (r.func)
      FUNC_MAP_LOAD: begin
        grid_x[r.row * MAPN + r.col] = r.mdx;
        grid_y[r.row * MAPN + r.col] = r.mdy;
        grid_set[r.row * MAPN + r.col] = 1'b1;
      end
      FUNC_PIX_LOAD: begin
        if (r.px < IMG_W && r.py < IMG_H) begin
          raw_img[r.py * IMG_W + r.px] = r.pv;
          raw_set[r.py * IMG_W + r.px] = 1'b1;
        end
      end
      FUNC_COMPUTE: begin
        undistort(r.dx, r.dy, hit, addr);
        o.pixel = hit ? raw_img[addr] : REJECT_PIXEL;
        o.in_range = hit;
        pending_pixels.push_back(o);
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(input req_t r);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    func_i = r.func; map_col_i = r.col; map_row_i = r.row;
    map_dx_i = r.mdx; map_dy_i = r.mdy;
    pixel_x_i = r.px; pixel_y_i = r.py; pixel_value_i = r.pv;
    dest_x_i = r.dx; dest_y_i = r.dy;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    n_requests++;
    commit_request(r);
  endtask

  function automatic req_t blank_request(input logic [FUNC_BITS-1:0] f);
    req_t r;
    r.func = f;
    r.col = $urandom; r.row = $urandom; r.mdx = $urandom; r.mdy = $urandom;
    r.px = $urandom; r.py = $urandom; r.pv = $urandom;
    r.dx = $urandom; r.dy = $urandom;
    return r;
  endfunction

  task automatic load_map(input int unsigned idx, input logic [MAP_VAL_BITS-1:0] vx,
                          input logic [MAP_VAL_BITS-1:0] vy);
    req_t r;
    r = blank_request(FUNC_MAP_LOAD);
    r.col = idx % MAPN; r.row = idx / MAPN; r.mdx = vx; r.mdy = vy;
    send_request(r);
  endtask

  // fills any map corner or raw pixel the lookup would touch before it is issued
  task automatic issue_compute(input logic [DEST_X_BITS-1:0] dx,
                               input logic [DEST_Y_BITS-1:0] dy);
    int unsigned cr[4], addr;
    longint rx, ry;
    bit hit;
    req_t r;
    map_corners(dx, dy, cr, rx, ry);
    for (int k = 0; k < 4; k++)
      if (!grid_set[cr[k]]) load_map(cr[k], rand_map_val(), rand_map_val());
    undistort(dx, dy, hit, addr);
    if (hit && !raw_set[addr]) begin
      r = blank_request(FUNC_PIX_LOAD);
      r.px = addr % IMG_W; r.py = addr / IMG_W;
      send_request(r);
    end
    r = blank_request(FUNC_COMPUTE);
    r.dx = dx; r.dy = dy;
    send_request(r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_index_i = idx; cfg_data_i = data; cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_IMG_WIDTH) width_reg = data;
    else height_reg = data[CFG_H_BITS-1:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic test_directed();
    req_t r;
    // corner patch at dest (0,119) forced to exactly 1.0: clamps to last row/column
    for (int k = 0; k < 2; k++) begin
      load_map(k, 20'sd65536, 20'sd65536);
      load_map(MAPN + k, 20'sd65536, 20'sd65536);
    end
    issue_compute(9'd0, 7'd119);
    // same patch with its first corner just below zero: the blend stays in range
    load_map(0, -20'sd1, 20'sd0);
    issue_compute(9'd0, 7'd119);
    load_map(1, 20'h7FFFF, 20'h80000);
    issue_compute(9'd0, 7'd119);
    issue_compute(9'd319, 7'd0);
    issue_compute(9'd511, 7'd127);   // both saturate
    issue_compute(9'd320, 7'd120);
    issue_compute(9'd160, 7'd60);
    r = blank_request(FUNC_PIX_LOAD);
    r.px = 10'd1023; r.py = 8'd255; r.pv = 8'hFF;  // beyond the store: ignored
    send_request(r);
    r = blank_request(FUNC_PIX_LOAD);
    r.px = 10'd639; r.py = 8'd239; r.pv = 8'h00;
    send_request(r);
    r = blank_request(FUNC_PIX_LOAD);
    r.px = 10'd0; r.py = 8'd0; r.pv = 8'hA5;
    send_request(r);
    send_request(blank_request(FUNC_UNUSED));
    load_map(MAPN * MAPN - 1, 20'h00000, 20'hFFFFF);
  endtask

  // the phase sends at least count requests, fill loads included
  task automatic random_phase(input int unsigned count);
    int unsigned pick, stop;
    stop = n_requests + count;
    while (n_requests < stop) begin
      pick = $urandom_range(99);
      if (pick < 55) issue_compute($urandom_range(319), $urandom_range(119));
      else if (pick < 60) issue_compute($urandom, $urandom);
      else if (pick < 78) load_map($urandom_range(MAPN * MAPN - 1), rand_map_val(),
                                   rand_map_val());
      else if (pick < 95) send_request(blank_request(FUNC_PIX_LOAD));
      else send_request(blank_request(FUNC_UNUSED));
    end
  endtask

  task automatic test_config_sweep();
    logic [CFG_DATA_BITS-1:0] widths [5] = '{10'd640, 10'd1, 10'd16, 10'd1023, 10'd0};
    logic [CFG_DATA_BITS-1:0] heights[5] = '{10'd240, 10'd1, 10'd8, 10'h3FF, 10'd0};
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_IMG_WIDTH, widths[p]);
      write_reg(REG_IMG_HEIGHT, heights[p]);
      calm = (p == 2);
      random_phase(60);
      calm = 1'b0;
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_IMG_WIDTH, $urandom_range(640, 1));
      write_reg(REG_IMG_HEIGHT, $urandom);
      calm = (p == 1);
      random_phase(175);
      calm = 1'b0;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_config_sweep();
    test_random_traffic();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d requests, %0d remap results, %0d of them rejected",
             n_requests, n_results, n_rejects);
    $display("image sizes swept from 1x1 to 640x240 including out-of-range settings");
    if (!failed) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
hdl/lur_pkg.sv
hdl/lur_front.sv
hdl/lur_fifo.sv
hdl/lur_back.sv
hdl/lens_undistort_remap.sv
test/tb_lens_undistort_remap.sv
